>>> design/htil_pkg.sv
// Shared constants, codes and types of the hash table block.
package htil_pkg;

    localparam int NUM_BUCKETS  = 6;
    localparam int BUCKET_DEPTH = 8;
    localparam int SLOT_COUNT   = NUM_BUCKETS * BUCKET_DEPTH;

    localparam int KEY_W   = 64;
    localparam int NAME_W  = 8;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = KEY_W + NAME_W;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // key bits folded into the bucket remainder per cycle
    localparam int HASH_BITS  = 8;
    localparam int HASH_CYC   = KEY_W / HASH_BITS;
    localparam int HASH_CNT_W = $clog2(HASH_CYC);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [NAME_W-1:0] name;
        logic [BKT_W-1:0]  bucket;
    } t_work;

endpackage

>>> design/htil_ifs.sv
// Request and result channel interfaces of the hash table block.
interface htil_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [htil_pkg::KEY_W-1:0]  key;
    logic [htil_pkg::NAME_W-1:0] entry_name;

    modport source (output valid, output func, output key, output entry_name, input ready);
    modport sink   (input valid, input func, input key, input entry_name, output ready);
endinterface

interface htil_res_if;
    logic                       valid;
    logic                       ready;
    logic [htil_pkg::STAT_W-1:0] status;
    logic [htil_pkg::NAME_W-1:0] found_name;
    logic [htil_pkg::KEY_W-1:0]  found_key;

    modport source (output valid, output status, output found_name, output found_key,
                    input ready);
    modport sink   (input valid, input status, input found_name, input found_key,
                    output ready);
endinterface

>>> design/hash_table_insert_lookup_top.sv
// Top level of the hash table block: front end, work queue and table engine.
// Usage:
//   i_req carries one operation per beat: func insert or lookup, a 64-bit key
//   and a name byte. o_res returns exactly one result beat per request, in
//   request order: status (ok or found, not found, bucket full), the found
//   name and key on a lookup hit, zero otherwise.
//   The front end reduces the key mod the bucket count, 8 key bits per cycle,
//   then hands the request on to wait in a two-entry queue.
//   The table engine writes an insert into the next free slot of its bucket
//   or reports the bucket full; a lookup scans the bucket, reading the entry
//   store one slot per cycle, newest first, until it hits or runs out.
//   The front end takes a new request as it hands the last one on, so front
//   end and engine overlap across requests.
//   Reset empties all buckets at once; stored entries are not cleared.
//   A stalled o_res holds its beat; the engine and then the queue and front
//   end fill up and drop i_req.ready until the result is taken.
module hash_table_insert_lookup_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htil_req_if.sink   i_req,
    htil_res_if.source o_res
);

    logic            push_valid;
    logic            push_ready;
    htil_pkg::t_work push_data;
    logic            pop_valid;
    logic            pop_ready;
    htil_pkg::t_work pop_data;

    htil_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    htil_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    htil_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_res       (o_res)
    );

endmodule

>>> design/htil_ram.sv
// Generic single write port, single read port RAM with registered read.
module htil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/htil_front.sv
// Front end: accepts requests and reduces the key to its bucket index.
module htil_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    htil_req_if.sink        i_req,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output htil_pkg::t_work o_push_data
);

    logic                               r_busy;
    logic                               r_done;
    logic [htil_pkg::HASH_CNT_W-1:0]    r_cnt;
    logic [htil_pkg::BKT_W-1:0]         r_rem;
    logic                               r_func;
    logic [htil_pkg::KEY_W-1:0]         r_key;
    logic [htil_pkg::NAME_W-1:0]        r_name;

    logic                               push;
    logic                               take;
    logic [htil_pkg::BKT_W-1:0]         n_rem;

    // remainder mod bucket count, one key bit per step, MSB first
    function automatic logic [htil_pkg::BKT_W-1:0] mod_step(
        input logic [htil_pkg::BKT_W-1:0]     rem_in,
        input logic [htil_pkg::HASH_BITS-1:0] bits_in
    );
        logic [htil_pkg::BKT_W:0] acc;
        logic [htil_pkg::BKT_W:0] nb;
        logic [htil_pkg::BKT_W-1:0] rem;
        nb  = (htil_pkg::BKT_W + 1)'(htil_pkg::NUM_BUCKETS);
        rem = rem_in;
        for (int i = htil_pkg::HASH_BITS - 1; i >= 0; i--) begin
            acc = {rem, bits_in[i]};
            if (acc >= nb) begin
                acc = acc - nb;
            end
            rem = acc[htil_pkg::BKT_W-1:0];
        end
        return rem;
    endfunction

    assign push        = r_busy && r_done && i_push_ready;
    assign i_req.ready = !r_busy || push;
    assign take        = i_req.valid && i_req.ready;
    assign n_rem       = mod_step(r_rem, r_key[r_cnt * htil_pkg::HASH_BITS +: htil_pkg::HASH_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (push) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy && !r_done && r_cnt == '0) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_func <= i_req.func;
            r_key  <= i_req.key;
            r_name <= i_req.entry_name;
            r_rem  <= '0;
            r_cnt  <= htil_pkg::HASH_CNT_W'(htil_pkg::HASH_CYC - 1);
        end else if (r_busy && !r_done) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_push_valid       = r_busy && r_done;
    assign o_push_data.func   = r_func;
    assign o_push_data.key    = r_key;
    assign o_push_data.name   = r_name;
    assign o_push_data.bucket = r_rem;

endmodule

>>> design/htil_fifo.sv
// Two-entry work queue between the front end and the table engine.
module htil_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  htil_pkg::t_work i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output htil_pkg::t_work o_pop_data
);

    htil_pkg::t_work              r_mem [htil_pkg::Q_DEPTH];
    logic [htil_pkg::Q_PTR_W-1:0] r_wr;
    logic [htil_pkg::Q_PTR_W-1:0] r_rd;
    logic [htil_pkg::Q_CNT_W-1:0] r_count;
    logic                         push;
    logic                         pop;

    assign o_push_ready = r_count != htil_pkg::Q_CNT_W'(htil_pkg::Q_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == htil_pkg::Q_PTR_W'(htil_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == htil_pkg::Q_PTR_W'(htil_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= htil_pkg::Q_CNT_W'(htil_pkg::Q_DEPTH))
        else $error("work queue count beyond its depth");

endmodule

>>> design/htil_back.sv
// Table engine: bucket fill counts, entry store, insert and newest-first scan.
module htil_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  htil_pkg::t_work i_pop_data,
    htil_res_if.source      o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic                           r_func;
    logic [htil_pkg::KEY_W-1:0]     r_key;
    logic [htil_pkg::NAME_W-1:0]    r_name;
    logic [htil_pkg::BKT_W-1:0]     r_bucket;
    logic [htil_pkg::FILL_W-1:0]    r_fill [htil_pkg::NUM_BUCKETS];
    logic [htil_pkg::FILL_W-1:0]    r_rem, n_rem;
    logic                           r_pend, n_pend;

    logic                           r_ovalid;
    logic [htil_pkg::STAT_W-1:0]    r_status, n_status;
    logic [htil_pkg::NAME_W-1:0]    r_oname, n_oname;
    logic [htil_pkg::KEY_W-1:0]     r_okey, n_okey;
    logic                           out_load;
    logic                           can_out;

    logic [htil_pkg::FILL_W-1:0]    fill_cur;
    logic                           fill_inc;
    logic [htil_pkg::SLOT_W-1:0]    base;
    logic                           wr_en;
    logic [htil_pkg::SLOT_W-1:0]    wr_addr;
    logic                           rd_en;
    logic [htil_pkg::SLOT_W-1:0]    rd_addr;
    logic [htil_pkg::ENTRY_W-1:0]   rd_data;
    logic [htil_pkg::KEY_W-1:0]     rd_key;
    logic [htil_pkg::NAME_W-1:0]    rd_name;
    logic                           hit;

    htil_ram #(
        .WIDTH (htil_pkg::ENTRY_W),
        .DEPTH (htil_pkg::SLOT_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_key, r_name}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_key   = rd_data[htil_pkg::ENTRY_W-1:htil_pkg::NAME_W];
    assign rd_name  = rd_data[htil_pkg::NAME_W-1:0];
    assign fill_cur = r_fill[r_bucket];
    assign base     = htil_pkg::SLOT_W'(r_bucket) * htil_pkg::SLOT_W'(htil_pkg::BUCKET_DEPTH);
    assign wr_addr  = base + htil_pkg::SLOT_W'(fill_cur);
    assign rd_addr  = base + htil_pkg::SLOT_W'(r_rem - 1'b1);
    assign hit      = r_pend && (rd_key == r_key);
    assign can_out  = !r_ovalid || o_res.ready;
    assign o_pop_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_status = htil_pkg::STAT_OK;
        n_oname  = '0;
        n_okey   = '0;
        out_load = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        fill_inc = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == htil_pkg::FUNC_LOOKUP) begin
                    n_rem   = fill_cur;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end else if (can_out) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (fill_cur == htil_pkg::FILL_W'(htil_pkg::BUCKET_DEPTH)) begin
                        n_status = htil_pkg::STAT_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        fill_inc = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // hold the read data until the result register frees up
                    if (can_out) begin
                        out_load = 1'b1;
                        n_oname  = rd_name;
                        n_okey   = r_key;
                        n_state  = S_IDLE;
                    end
                end else if (r_rem != '0) begin
                    rd_en  = 1'b1;
                    n_rem  = r_rem - 1'b1;
                    n_pend = 1'b1;
                end else if (can_out) begin
                    out_load = 1'b1;
                    n_status = htil_pkg::STAT_MISS;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_rem    <= '0;
            r_ovalid <= 1'b0;
            for (int b = 0; b < htil_pkg::NUM_BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_rem   <= n_rem;
            if (fill_inc) begin
                r_fill[r_bucket] <= fill_cur + 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) begin
            r_func   <= i_pop_data.func;
            r_key    <= i_pop_data.key;
            r_name   <= i_pop_data.name;
            r_bucket <= i_pop_data.bucket;
        end
        if (out_load) begin
            r_status <= n_status;
            r_oname  <= n_oname;
            r_okey   <= n_okey;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.status     = r_status;
    assign o_res.found_name = r_oname;
    assign o_res.found_key  = r_okey;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (fill_cur < htil_pkg::FILL_W'(htil_pkg::BUCKET_DEPTH)))
        else $error("write into a full bucket");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state != S_IDLE) && can_out)
        else $error("result loaded while idle or while the result register is held");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend && !$past(rd_en)) |-> $stable(rd_data))
        else $error("scan read data changed without a read");

endmodule
